/* hdl/madt_pkg.sv */
// Shared types and constants for the MADT entry parser.
// Standalone package; used by madt_entry_parser_top.
package madt_pkg;

    localparam logic [31:0] HDR_END      = 32'd44;
    localparam logic [31:0] LEN_MIN_IDX  = 32'd8;
    localparam logic [7:0]  REC_MIN_LEN  = 8'd2;

    localparam logic        KIND_BYTE    = 1'b0;
    localparam logic        KIND_QUERY   = 1'b1;

    localparam logic [7:0]  REC_LAPIC    = 8'd0;
    localparam logic [7:0]  REC_IOAPIC   = 8'd1;
    localparam logic [7:0]  REC_LAPIC_OV = 8'd5;

    localparam logic [7:0]  OFF_TYPE     = 8'd0;
    localparam logic [7:0]  OFF_LEN      = 8'd1;
    localparam logic [7:0]  OFF_ID       = 8'd3;
    localparam logic [7:0]  OFF_FLD_LO   = 8'd4;
    localparam logic [7:0]  OFF_FLD_HI   = 8'd11;

    typedef enum logic [1:0] {
        ST_COMPLETE   = 2'd0,
        ST_BAD_RECORD = 2'd1,
        ST_TOO_SHORT  = 2'd2
    } t_status;

endpackage

/* hdl/madt_entry_parser_top.sv */
// MADT entry parser: one word per cycle, result in the cycle after acceptance.
// Throughput 1 word per cycle while o_valid is taken or empty.
// Id store is a registered-read memory, written at the record end, read by queries.
// Reset (i_rst_n low, synchronous) clears counters, bases and the result slot;
// id store contents stay undefined until written. Depends on madt_pkg.
module madt_entry_parser_top #(
    parameter int MAX_CPUS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_table_byte,
    input  logic [7:0]  i_cpu_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_result_kind,
    output logic [4:0]  o_cpu_count,
    output logic [63:0] o_local_base,
    output logic [31:0] o_io_base,
    output logic [31:0] o_irq_base,
    output logic [1:0]  o_parse_status,
    output logic [7:0]  o_apic_id
);
    import madt_pkg::*;

    localparam int CW = $clog2(MAX_CPUS + 1);
    localparam int IW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

    logic [31:0]   r_byte_count,   n_byte_count;
    logic [31:0]   r_table_length, n_table_length;
    logic [7:0]    r_rec_offset,   n_rec_offset;
    logic [7:0]    r_rec_type,     n_rec_type;
    logic [7:0]    r_rec_length,   n_rec_length;
    logic [63:0]   r_field_shift,  n_field_shift;
    logic [7:0]    r_rec_id,       n_rec_id;
    logic          r_stopped,      n_stopped;
    logic [CW-1:0] r_found_count,  n_found_count;
    logic [63:0]   r_local_base,   n_local_base;
    logic [31:0]   r_io_base,      n_io_base;
    logic [31:0]   r_irq_base,     n_irq_base;

    logic          r_out_valid;
    logic          r_out_kind;
    logic [4:0]    r_out_count;
    logic [63:0]   r_out_local;
    logic [31:0]   r_out_io;
    logic [31:0]   r_out_irq;
    t_status       r_out_status;
    logic          r_out_hit;
    logic [7:0]    r_rd_data;

    logic [7:0]    id_mem [MAX_CPUS];

    logic          accept;
    logic          fresh;
    logic          summary;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [7:0]    wr_data;
    logic          query_hit;
    logic [31:0]   cnt;
    logic [32:0]   rec_end;
    logic          rec_bad;
    logic          rec_done;
    logic [CW-1:0] sum_count;
    logic [CW-1:0] qry_count;
    t_status       sum_status;

    assign accept  = i_valid && o_ready;
    assign o_ready = !r_out_valid || i_ready;
    assign fresh   = (r_byte_count == 32'd0);
    assign query_hit = (9'(i_cpu_index) < 9'(r_found_count));

    always_comb begin
        n_byte_count   = r_byte_count;
        n_table_length = fresh ? '0 : r_table_length;
        n_rec_offset   = fresh ? '0 : r_rec_offset;
        n_rec_type     = fresh ? '0 : r_rec_type;
        n_rec_length   = fresh ? '0 : r_rec_length;
        n_field_shift  = fresh ? '0 : r_field_shift;
        n_rec_id       = fresh ? '0 : r_rec_id;
        n_stopped      = fresh ? 1'b0 : r_stopped;
        n_found_count  = fresh ? '0 : r_found_count;
        n_local_base   = fresh ? '0 : r_local_base;
        n_io_base      = fresh ? '0 : r_io_base;
        n_irq_base     = fresh ? '0 : r_irq_base;
        wr_en    = 1'b0;
        wr_idx   = n_found_count[IW-1:0];
        wr_data  = '0;
        rec_end  = {1'b0, r_byte_count} - 33'd1 + 33'(i_table_byte);
        rec_bad  = (i_table_byte < REC_MIN_LEN) || (rec_end > {1'b0, r_table_length});
        rec_done = 1'b0;
        summary  = 1'b0;
        cnt      = r_byte_count + 32'd1;

        if (r_byte_count >= 32'd4 && r_byte_count <= 32'd7) begin
            n_table_length[{r_byte_count[1:0], 3'b000} +: 8] = i_table_byte;
        end else if (r_byte_count >= 32'd36 && r_byte_count <= 32'd39) begin
            n_local_base[{r_byte_count[1:0], 3'b000} +: 8] = i_table_byte;
        end else if (r_byte_count >= HDR_END && !n_stopped) begin
            if (n_rec_offset == OFF_TYPE) begin
                n_rec_type   = i_table_byte;
                n_rec_offset = n_rec_offset + 8'd1;
            end else begin
                if (n_rec_offset == OFF_LEN) begin
                    if (rec_bad) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_rec_length = i_table_byte;
                    end
                end else if (n_rec_offset == OFF_ID) begin
                    n_rec_id = i_table_byte;
                end else if (n_rec_offset >= OFF_FLD_LO && n_rec_offset <= OFF_FLD_HI) begin
                    n_field_shift[{n_rec_offset[2:0] ^ 3'b100, 3'b000} +: 8] = i_table_byte;
                end
                if (!n_stopped) begin
                    if ((9'(n_rec_offset) + 9'd1) >= 9'(n_rec_length)) begin
                        rec_done = 1'b1;
                    end else begin
                        n_rec_offset = n_rec_offset + 8'd1;
                    end
                end
            end
        end

        if (rec_done) begin
            if (n_rec_type == REC_LAPIC) begin
                if (n_field_shift[0] && (32'(n_found_count) < 32'(MAX_CPUS))) begin
                    wr_en         = 1'b1;
                    wr_data       = n_rec_id;
                    n_found_count = n_found_count + CW'(1);
                end
            end else if (n_rec_type == REC_IOAPIC) begin
                if (n_io_base == 32'd0) begin
                    n_io_base  = n_field_shift[31:0];
                    n_irq_base = n_field_shift[63:32];
                end
            end else if (n_rec_type == REC_LAPIC_OV) begin
                n_local_base = n_field_shift;
            end
            n_rec_offset  = '0;
            n_rec_type    = '0;
            n_rec_length  = '0;
            n_field_shift = '0;
            n_rec_id      = '0;
        end

        if (cnt >= LEN_MIN_IDX && cnt >= n_table_length) begin
            summary      = 1'b1;
            n_byte_count = '0;
        end else begin
            n_byte_count = cnt;
        end
    end

    assign sum_count = (n_found_count == '0) ? CW'(1) : n_found_count;
    assign qry_count = (r_found_count == '0) ? CW'(1) : r_found_count;

    always_comb begin
        if (n_table_length < HDR_END) begin
            sum_status = ST_TOO_SHORT;
        end else if (n_stopped) begin
            sum_status = ST_BAD_RECORD;
        end else begin
            sum_status = ST_COMPLETE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_table_length <= '0;
            r_rec_offset   <= '0;
            r_rec_type     <= '0;
            r_rec_length   <= '0;
            r_field_shift  <= '0;
            r_rec_id       <= '0;
            r_stopped      <= 1'b0;
            r_found_count  <= '0;
            r_local_base   <= '0;
            r_io_base      <= '0;
            r_irq_base     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (accept && i_kind == KIND_BYTE) begin
                r_byte_count   <= n_byte_count;
                r_table_length <= n_table_length;
                r_rec_offset   <= n_rec_offset;
                r_rec_type     <= n_rec_type;
                r_rec_length   <= n_rec_length;
                r_field_shift  <= n_field_shift;
                r_rec_id       <= n_rec_id;
                r_stopped      <= n_stopped;
                r_found_count  <= n_found_count;
                r_local_base   <= n_local_base;
                r_io_base      <= n_io_base;
                r_irq_base     <= n_irq_base;
            end
            if (accept) begin
                r_out_valid <= (i_kind == KIND_QUERY) || summary;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_kind == KIND_QUERY) begin
                r_out_kind   <= KIND_QUERY;
                r_out_count  <= 5'(qry_count);
                r_out_local  <= r_local_base;
                r_out_io     <= r_io_base;
                r_out_irq    <= r_irq_base;
                r_out_status <= ST_COMPLETE;
                r_out_hit    <= query_hit;
            end else begin
                r_out_kind   <= KIND_BYTE;
                r_out_count  <= 5'(sum_count);
                r_out_local  <= n_local_base;
                r_out_io     <= n_io_base;
                r_out_irq    <= n_irq_base;
                r_out_status <= sum_status;
                r_out_hit    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_kind == KIND_BYTE && wr_en) begin
            id_mem[wr_idx] <= wr_data;
        end
        if (accept) begin
            r_rd_data <= id_mem[i_cpu_index[IW-1:0]];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_cpu_count    = r_out_count;
    assign o_local_base   = r_out_local;
    assign o_io_base      = r_out_io;
    assign o_irq_base     = r_out_irq;
    assign o_parse_status = r_out_status;
    assign o_apic_id      = r_out_hit ? r_rd_data : 8'd0;

    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_found_count) <= 32'(MAX_CPUS))
        else $error("found count beyond CPU limit");

    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !o_ready)
        else $error("word accepted while result slot full");

    a_summary_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == KIND_BYTE && summary) |=> (r_byte_count == 32'd0))
        else $error("byte count not rewound after summary");

    a_query_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == KIND_QUERY) |=> $stable(r_byte_count))
        else $error("query disturbed the byte stream");

endmodule
